FILE: src/pcins_pkg.sv
package pcins_pkg;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcAll  = 32'hFFFFFFFF;

  // offset of the last IHDR byte, and the value the position saturates at
  localparam logic [5:0] HeadLast = 6'd32;
  localparam logic [5:0] PosPast  = 6'd33;

  // chunk byte indexes
  localparam logic [4:0] ChunkFinal   = 5'd20;
  localparam logic [4:0] CrcFirst     = 5'd4;
  localparam logic [4:0] CrcLastData  = 5'd16;

  // register indexes (paddr bit 2)
  localparam logic RegEnable = 1'b0;
  localparam logic RegPpm    = 1'b1;

  localparam logic        EnableReset = 1'b1;
  localparam logic [31:0] PpmReset    = 32'd15748;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       insert;
  } item_t;

  function automatic logic [31:0] crc_byte(logic [31:0] c_in, logic [7:0] b);
    logic [31:0] c;
    c = c_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? (CrcPoly ^ (c >> 1)) : (c >> 1);
    end
    return c;
  endfunction

  // {check, expected byte} for the header offsets that are checked
  function automatic logic [8:0] hdr_expect(logic [5:0] pos);
    logic [8:0] r;
    case (pos)
      6'd0:    r = {1'b1, 8'd137};
      6'd1:    r = {1'b1, 8'd80};
      6'd2:    r = {1'b1, 8'd78};
      6'd3:    r = {1'b1, 8'd71};
      6'd4:    r = {1'b1, 8'd13};
      6'd5:    r = {1'b1, 8'd10};
      6'd6:    r = {1'b1, 8'd26};
      6'd7:    r = {1'b1, 8'd10};
      6'd12:   r = {1'b1, 8'd73};
      6'd13:   r = {1'b1, 8'd72};
      6'd14:   r = {1'b1, 8'd68};
      6'd15:   r = {1'b1, 8'd82};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // byte idx of the pHYs chunk; crc holds the running register, not inverted
  function automatic logic [7:0] chunk_byte(logic [4:0] idx, logic [31:0] ppm,
                                            logic [31:0] crc);
    logic [7:0]  r;
    logic [31:0] fin;
    fin = crc ^ CrcAll;
    case (idx)
      5'd3:  r = 8'd9;
      5'd4:  r = 8'd112;
      5'd5:  r = 8'd72;
      5'd6:  r = 8'd89;
      5'd7:  r = 8'd115;
      5'd8, 5'd12:  r = ppm[31:24];
      5'd9, 5'd13:  r = ppm[23:16];
      5'd10, 5'd14: r = ppm[15:8];
      5'd11, 5'd15: r = ppm[7:0];
      5'd16: r = 8'd1;
      5'd17: r = fin[31:24];
      5'd18: r = fin[23:16];
      5'd19: r = fin[15:8];
      5'd20: r = fin[7:0];
      default: r = 8'd0;
    endcase
    return r;
  endfunction

endpackage

FILE: src/pcins_hdr_track.sv
module pcins_hdr_track (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          data_i,
  input  logic                last_i,
  input  logic                enable_i,
  output pcins_pkg::item_t    item_o
);

  logic [5:0] pos_q, pos_d;
  logic       match_q, match_d;
  logic [8:0] expect_w;
  logic       match_now;

  always_comb begin
    expect_w  = pcins_pkg::hdr_expect(pos_q);
    match_now = match_q && !(expect_w[8] && (data_i != expect_w[7:0]));

    item_o.data   = data_i;
    item_o.last   = last_i;
    item_o.insert = (pos_q == pcins_pkg::HeadLast) && match_now && enable_i;

    if (last_i) begin
      pos_d   = 6'd0;
      match_d = 1'b1;
    end else begin
      match_d = match_now;
      pos_d   = (pos_q < pcins_pkg::PosPast) ? pos_q + 6'd1 : pcins_pkg::PosPast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 6'd0;
      match_q <= 1'b1;
    end else if (accept_i) begin
      pos_q   <= pos_d;
      match_q <= match_d;
    end
  end

endmodule

FILE: src/pcins_chunk_gen.sv
module pcins_chunk_gen (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  pcins_pkg::item_t    in_item_i,
  input  logic [31:0]         ppm_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o,
  output logic                out_ins_o
);

  logic        out_valid_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic        out_ins_q;
  logic        pend_q;
  logic [4:0]  idx_q;
  logic        last_q;
  logic [31:0] ppm_q;
  logic [31:0] crc_q;

  logic        load_free;
  logic        in_acc;
  logic [7:0]  chunk_w;
  logic        crc_span;

  always_comb begin
    load_free  = !out_valid_q || out_ready_i;
    in_ready_o = load_free && !pend_q;
    in_acc     = in_valid_i && in_ready_o;
    chunk_w    = pcins_pkg::chunk_byte(idx_q, ppm_q, crc_q);
    crc_span   = idx_q inside {[pcins_pkg::CrcFirst:pcins_pkg::CrcLastData]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      idx_q       <= 5'd0;
    end else if (load_free) begin
      if (pend_q) begin
        out_valid_q <= 1'b1;
        pend_q      <= (idx_q != pcins_pkg::ChunkFinal);
        idx_q       <= idx_q + 5'd1;
      end else if (in_valid_i) begin
        out_valid_q <= 1'b1;
        pend_q      <= in_item_i.insert;
        idx_q       <= 5'd0;
      end else begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_free && pend_q) begin
      out_byte_q <= chunk_w;
      out_last_q <= (idx_q == pcins_pkg::ChunkFinal) ? last_q : 1'b0;
      out_ins_q  <= 1'b1;
      if (crc_span) begin
        crc_q <= pcins_pkg::crc_byte(crc_q, chunk_w);
      end
    end else if (in_acc) begin
      out_byte_q <= in_item_i.data;
      out_last_q <= in_item_i.last && !in_item_i.insert;
      out_ins_q  <= 1'b0;
      last_q     <= in_item_i.last;
      ppm_q      <= ppm_i;
      crc_q      <= pcins_pkg::CrcAll;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_last_o  = out_last_q;
  assign out_ins_o   = out_ins_q;

  a_no_input_while_chunk : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> !in_ready_o)
    else $error("input taken while chunk bytes pending");

  a_chunk_starts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_item_i.insert) |=> (pend_q && idx_q == 5'd0 && !out_ins_q))
    else $error("chunk did not start after triggering byte");

  a_idx_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (idx_q <= pcins_pkg::ChunkFinal))
    else $error("chunk index out of range");

  a_last_only_final : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_ins_q && out_last_q) |-> !pend_q)
    else $error("inserted byte marked last before chunk end");

endmodule

FILE: src/png_phys_chunk_inserter_unit.sv
// png pHYs chunk inserter
// s_axis: input stream, one PNG byte per item (tdata = data byte, tlast = final byte)
// m_axis: result stream (tdata = byte, tlast = final byte, tuser = inserted flag)
// every input byte is passed through; after stream offset 32 (end of IHDR) a
// 21-byte pHYs chunk with its CRC-32 follows when the header matched and
// enable_stamp is set
// apb port: 0x0 enable_stamp (bit 0), 0x4 pixels_per_metre; pready always high
// a result item is registered and shows in the cycle after its input item is accepted
// throughput: one item per cycle while the output is not stalled; after the
// triggering byte the input is held off until the last of the 21 chunk bytes
// is loaded, since the single output register is fed by the chunk sequencer
// one byte a cycle while the output moves (crc is folded in as it goes)
// a stalled output holds its item and the input stays ready only while the
// output register is empty or empties in the same cycle
// reset: stream position 0, header match set, registers to 1 and 15748
// registers are sampled when offset 32 is accepted
module png_phys_chunk_inserter_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,
  output logic        m_axis_tuser,   // [0] inserted
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic              enable_q;
  logic [31:0]       ppm_q;
  logic              cfg_wr;
  logic              in_acc;
  pcins_pkg::item_t  item_w;

  // apb write at access phase, register chosen by address bit 2
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= pcins_pkg::EnableReset;
      ppm_q    <= pcins_pkg::PpmReset;
    end else if (cfg_wr) begin
      if (paddr[2] == pcins_pkg::RegEnable) begin
        enable_q <= pwdata[0];
      end else begin
        ppm_q <= pwdata;
      end
    end
  end

  assign prdata = (paddr[2] == pcins_pkg::RegPpm) ? ppm_q : {31'd0, enable_q};

  assign in_acc = s_axis_tvalid && s_axis_tready;

  // header position and signature check, decides insertion per byte
  pcins_hdr_track u_hdr (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .data_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .enable_i (enable_q),
    .item_o   (item_w)
  );

  // output register and chunk sequencer
  pcins_chunk_gen u_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (item_w),
    .ppm_i       (ppm_q),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_byte_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast),
    .out_ins_o   (m_axis_tuser)
  );

endmodule

FILE: tb/png_phys_chunk_inserter_unit_tb.sv
module png_phys_chunk_inserter_unit_tb;

  // stream layout constants, most significant byte first
  localparam logic [63:0] PngSig  = 64'h89504E470D0A1A0A;
  localparam logic [31:0] IhdrTag = 32'h49484452;
  localparam logic [31:0] PhysTag = 32'h70485973;

  localparam int ItemTarget    = 500;
  localparam int CalmTail      = 60;    // last items sent with no idling on either side
  localparam int HoldOffCycles = 300;   // long receiver stall, fills the block
  localparam int WatchdogLimit = 2000;  // cycles with no item moving on either side
  localparam int DrainCycles   = 30;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       ins;
  } stamped_byte_t;

  // one directed stream: its length, a header offset to corrupt (-1 for none),
  // the register setting to run it under, and whether it must pass unchanged
  typedef struct packed {
    int          len;
    int          bad_at;
    logic        en;
    logic [31:0] ppm;
    logic        plain;
  } stream_row_t;

  localparam stream_row_t DirectedRows [12] = '{
    '{33,  -1, 1'b1, pcins_pkg::PpmReset, 1'b0},  // exactly 33 bytes, last moves to chunk end
    '{36,  -1, 1'b1, pcins_pkg::PpmReset, 1'b0},
    '{20,  -1, 1'b1, pcins_pkg::PpmReset, 1'b1},  // short stream
    '{1,   -1, 1'b1, pcins_pkg::PpmReset, 1'b1},  // single byte
    '{32,  -1, 1'b1, pcins_pkg::PpmReset, 1'b1},  // ends one byte before the IHDR end
    '{34,   0, 1'b1, pcins_pkg::PpmReset, 1'b1},  // bad signature, first byte
    '{34,  15, 1'b1, pcins_pkg::PpmReset, 1'b1},  // bad chunk type, last letter
    '{34,  -1, 1'b0, pcins_pkg::PpmReset, 1'b1},  // stamping disabled
    '{34,  -1, 1'b1, 32'h0000_0000,       1'b0},
    '{33,  -1, 1'b1, 32'hFFFF_FFFF,       1'b0},
    '{50,  -1, 1'b1, 32'd2835,            1'b0},  // long stream, position saturates
    '{36,  -1, 1'b1, pcins_pkg::PpmReset, 1'b0}
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] data_byte
  logic        s_axis_tlast;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [7:0]  m_axis_tdata;   // [7:0] out_byte
  logic        m_axis_tlast;
  logic        m_axis_tuser;   // [0] inserted
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  png_phys_chunk_inserter_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // bytes the block still owes us, oldest first
  stamped_byte_t pending_results[$];

  // shadow of the block: registers and stream tracking
  logic        cfg_enable;
  logic [31:0] cfg_ppm;
  logic [5:0]  stream_pos;
  logic        header_ok;

  logic [7:0]  stream_buf [128];
  int          items_sent;
  int          mismatch_count;
  int          quiet_cycles;
  logic        idling_on;
  logic        hold_req;
  logic        hold_done;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s mismatch, got %0h expected %0h", $time, what, got, want);
    mismatch_count++;
  endtask

  // crc-32 over the pHYs type and its 9 data bytes, shifted in bit by bit
  function automatic logic [31:0] phys_chunk_crc(input logic [31:0] ppm);
    logic [103:0] body;
    logic [31:0]  r;
    body = {PhysTag, ppm, ppm, 8'd1};
    r = pcins_pkg::CrcAll;
    for (int i = 0; i < 13; i++) begin
      for (int k = 0; k < 8; k++) begin
        if (r[0] ^ body[103 - 8*i - 7 + k]) r = (r >> 1) ^ pcins_pkg::CrcPoly;
        else r = r >> 1;
      end
    end
    return r ^ pcins_pkg::CrcAll;
  endfunction

  // advances the shadow by one accepted byte; queues what it causes when keep is set
  function automatic void phys_predict(input logic [7:0] b, input logic l, input logic keep);
    int           p;
    logic         stamp;
    logic [167:0] chunk;
    p = int'(stream_pos);
    if (p < 8) begin
      if (b != PngSig[63 - 8*p -: 8]) header_ok = 1'b0;
    end else if (p >= 12 && p < 16) begin
      if (b != IhdrTag[31 - 8*(p - 12) -: 8]) header_ok = 1'b0;
    end
    stamp = (stream_pos == pcins_pkg::HeadLast) && header_ok && cfg_enable;
    if (keep) pending_results.push_back('{b, stamp ? 1'b0 : l, 1'b0});
    if (stamp && keep) begin
      chunk = {32'd9, PhysTag, cfg_ppm, cfg_ppm, 8'd1, phys_chunk_crc(cfg_ppm)};
      for (int i = 0; i < 21; i++)
        pending_results.push_back('{chunk[167 - 8*i -: 8], (i == 20) ? l : 1'b0, 1'b1});
    end
    if (l) begin
      stream_pos = '0;
      header_ok  = 1'b1;
    end else if (stream_pos < pcins_pkg::PosPast) begin
      stream_pos = stream_pos + 6'd1;
    end
  endfunction

  // all apb tasks start and end at a falling edge and release the bus before they return
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic apb_read(input logic [2:0] addr, output logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    data = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic check_registers();
    logic [31:0] rd;
    apb_read({pcins_pkg::RegEnable, 2'b00}, rd);
    if (rd !== {31'd0, cfg_enable})
      report_mismatch("enable_stamp readback", rd, {31'd0, cfg_enable});
    apb_read({pcins_pkg::RegPpm, 2'b00}, rd);
    if (rd !== cfg_ppm) report_mismatch("pixels_per_metre readback", rd, cfg_ppm);
  endtask

  // registers change only once the block has handed out everything it owes
  task automatic set_config(input logic en, input logic [31:0] ppm);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    apb_write({pcins_pkg::RegEnable, 2'b00}, {31'd0, en});
    cfg_enable = en;
    apb_write({pcins_pkg::RegPpm, 2'b00}, ppm);
    cfg_ppm = ppm;
    check_registers();
  endtask

  // offers one byte, with an optional gap ahead of it, and books its results
  task automatic send_byte(input logic [7:0] b, input logic l, input logic typed_plain);
    int gap;
    if (idling_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 9);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= l;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    items_sent++;
    // a stream that cannot stamp comes back byte for byte
    phys_predict(b, l, !typed_plain);
    if (typed_plain) pending_results.push_back('{b, l, 1'b0});
  endtask

  // signature, 4 length bytes, IHDR, then random content; optional corrupted byte
  task automatic play_stream(input int len, input int bad_at, input logic typed_plain);
    for (int i = 0; i < len; i++) begin
      if (i < 8) stream_buf[i] = PngSig[63 - 8*i -: 8];
      else if (i >= 12 && i < 16) stream_buf[i] = IhdrTag[31 - 8*(i - 12) -: 8];
      else stream_buf[i] = 8'($urandom_range(0, 255));
    end
    if (bad_at >= 0 && bad_at < len)
      stream_buf[bad_at] = stream_buf[bad_at] ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < len; i++)
      send_byte(stream_buf[i], i == len - 1, typed_plain);
  endtask

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int stall_left;
    int held;
    stall_left = 0;
    hold_done = 1'b0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        m_axis_tready <= 1'b0;
        held = 0;
        while (held < HoldOffCycles) begin
          @(negedge clk_i);
          held++;
        end
      end else if (idling_on && stall_left > 0) begin
        m_axis_tready <= 1'b0;
        stall_left--;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        stall_left = $urandom_range(0, 8);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // result checker, field by field against the oldest expectation
  always @(posedge clk_i) begin
    stamped_byte_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected item, byte", 32'(m_axis_tdata), 32'd0);
      end else begin
        want = pending_results.pop_front();
        if (m_axis_tdata !== want.data)
          report_mismatch("out_byte", 32'(m_axis_tdata), 32'(want.data));
        if (m_axis_tlast !== want.last)
          report_mismatch("out_last", 32'(m_axis_tlast), 32'(want.last));
        if (m_axis_tuser !== want.ins)
          report_mismatch("inserted", 32'(m_axis_tuser), 32'(want.ins));
      end
    end
  end

  // watchdog: no item moving on either side for too long ends the run
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("png_phys_chunk_inserter_unit_tb: errors");
        $finish;
      end
    end
  end

  initial begin
    int len;
    int bad_at;
    int kind;
    int streams;
    logic        new_en;
    logic [31:0] new_ppm;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    hold_req      = 1'b0;
    idling_on     = 1'b1;
    items_sent    = 0;
    mismatch_count = 0;
    cfg_enable    = pcins_pkg::EnableReset;
    cfg_ppm       = pcins_pkg::PpmReset;
    stream_pos    = '0;
    header_ok     = 1'b1;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // registers come up at their reset values
    check_registers();

    // directed streams, registers rewritten where a row asks for a new setting
    foreach (DirectedRows[r]) begin
      if (DirectedRows[r].en != cfg_enable || DirectedRows[r].ppm != cfg_ppm)
        set_config(DirectedRows[r].en, DirectedRows[r].ppm);
      play_stream(DirectedRows[r].len, DirectedRows[r].bad_at, DirectedRows[r].plain);
    end

    // random streams: mostly well formed, some short or with a broken header
    streams = 0;
    while (items_sent < ItemTarget) begin
      idling_on = (items_sent < ItemTarget - CalmTail) && ($urandom_range(0, 3) != 0);
      if (streams > 0 && $urandom_range(0, 3) == 0) begin
        new_en = ($urandom_range(0, 4) != 0);
        case ($urandom_range(0, 3))
          0:       new_ppm = 32'h0000_0000;
          1:       new_ppm = 32'hFFFF_FFFF;
          2:       new_ppm = $urandom();
          default: new_ppm = pcins_pkg::PpmReset;
        endcase
        set_config(new_en, new_ppm);
      end
      // one long receiver hold-off while the sender keeps offering the first random stream
      if (streams == 0) hold_req = 1'b1;
      kind = $urandom_range(0, 9);
      bad_at = -1;
      case (kind)
        0: len = $urandom_range(1, 32);
        1: begin
          len = $urandom_range(33, 60);
          bad_at = $urandom_range(0, 11);
          if (bad_at >= 8) bad_at = bad_at + 4;
        end
        2: len = 33;
        default: len = $urandom_range(33, 70);
      endcase
      play_stream(len, bad_at, 1'b0);
      streams++;
    end

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("png_phys_chunk_inserter_unit_tb: clean");
    end else begin
      $display("png_phys_chunk_inserter_unit_tb: errors");
    end
    $finish;
  end

endmodule
